### src/itl_pkg.sv
`default_nettype none
package itl_pkg;

	localparam int DEFAULT_DEPTH = 1024;

	localparam int CFG_W     = 11;
	localparam int IDX_W     = 10;
	localparam int KEY_W     = 63;
	localparam int VAL_W     = 63;
	localparam int STATUS_W  = 3;
	localparam int HALF_W    = 32;
	localparam int PROD_W    = KEY_W + VAL_W;
	localparam int SH_W      = $clog2(2 * HALF_W + 1);
	localparam int DIV_CNT_W = $clog2(VAL_W);
	localparam int MUL_SEL_W = 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_WRITTEN  = 3'd0,
		ST_INTERP   = 3'd1,
		ST_BELOW    = 3'd2,
		ST_ABOVE    = 3'd3,
		ST_TOO_FEW  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_FIRST,
		S_CHK_FIRST,
		S_CHK_LAST,
		S_SRCH_ISSUE,
		S_SRCH_CMP,
		S_CAP_LO,
		S_CAP_HI,
		S_PREP,
		S_MUL,
		S_MUL_WAIT,
		S_DIV_START,
		S_DIV_WAIT,
		S_RESULT,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		A_ZERO,
		A_MID,
		A_LO,
		A_HI
	} addr_sel_t;

	typedef enum logic [MUL_SEL_W-1:0] {
		MUL_LL,
		MUL_LH,
		MUL_HL,
		MUL_HH
	} mul_sel_t;

	typedef struct packed {
		logic      capture;
		logic      wr_en;
		logic      rd_en;
		addr_sel_t addr_sel;
		logic      step;
		logic      cap_lo;
		logic      cap_hi;
		logic      prep;
		logic      mul_en;
		mul_sel_t  mul_sel;
		logic      div_start;
		logic      res_en;
		logic      out_load;
		status_t   out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic too_few;
		logic e_lt_key;
		logic search_done;
		logic out_free;
		logic div_done;
	} dp_status_t;

endpackage
`default_nettype wire

### src/itl_mem.sv
`default_nettype none
module itl_mem #(
	parameter int DEPTH = itl_pkg::DEFAULT_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [AW-1:0]            wr_addr,
	input  wire logic [itl_pkg::KEY_W-1:0] wr_key,
	input  wire logic [itl_pkg::VAL_W-1:0] wr_val,
	input  wire logic                     rd_en,
	input  wire logic [AW-1:0]            rd_addr,
	output logic      [itl_pkg::KEY_W-1:0] rd_key,
	output logic      [itl_pkg::VAL_W-1:0] rd_val
);

	logic [itl_pkg::KEY_W-1:0] key_mem [DEPTH];
	logic [itl_pkg::VAL_W-1:0] val_mem [DEPTH];
	logic [itl_pkg::KEY_W-1:0] rd_key_q;
	logic [itl_pkg::VAL_W-1:0] rd_val_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	assign rd_key = rd_key_q;
	assign rd_val = rd_val_q;

endmodule
`default_nettype wire

### src/itl_div.sv
`default_nettype none
module itl_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [itl_pkg::KEY_W-1:0] dvd_hi,
	input  wire logic [itl_pkg::VAL_W-1:0] dvd_lo,
	input  wire logic [itl_pkg::KEY_W-1:0] divisor,
	output logic      [itl_pkg::VAL_W-1:0] quotient,
	output logic                           done
);

	logic [itl_pkg::KEY_W-1:0]     rem_q;
	logic [itl_pkg::VAL_W-1:0]     dq_q;
	logic [itl_pkg::KEY_W-1:0]     d_q;
	logic [itl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [itl_pkg::KEY_W:0]   trial;
	logic [itl_pkg::KEY_W:0]   diff;
	logic                      fits;
	logic [itl_pkg::KEY_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, dq_q[itl_pkg::VAL_W-1]};
		diff    = trial - {1'b0, d_q};
		fits    = trial >= {1'b0, d_q};
		rem_nxt = fits ? diff[itl_pkg::KEY_W-1:0] : trial[itl_pkg::KEY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= itl_pkg::DIV_CNT_W'(itl_pkg::VAL_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - itl_pkg::DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dvd_hi;
			dq_q  <= dvd_lo;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dq_q  <= {dq_q[itl_pkg::VAL_W-2:0], fits};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < d_q))
		else $error("remainder not below divisor");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("division done without a run");

endmodule
`default_nettype wire

### src/itl_datapath.sv
`default_nettype none
module itl_datapath #(
	parameter int TABLE_DEPTH = itl_pkg::DEFAULT_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write_en,
	input  wire logic [itl_pkg::CFG_W-1:0]    cfg_write_data,
	input  wire logic [itl_pkg::IDX_W-1:0]    entry_index,
	input  wire logic [itl_pkg::KEY_W-1:0]    key_word,
	input  wire logic [itl_pkg::VAL_W-1:0]    value_word,
	input  wire logic [itl_pkg::KEY_W-1:0]    energy,
	input  wire logic                         out_stall,
	input  wire itl_pkg::dp_cmd_t             cmd,
	output itl_pkg::dp_status_t               st,
	output logic                              out_valid,
	output logic      [itl_pkg::STATUS_W-1:0] status,
	output logic      [itl_pkg::VAL_W-1:0]    interpolated_value,
	output logic      [itl_pkg::IDX_W-1:0]    found_index
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = (itl_pkg::CFG_W > AW + 1) ? itl_pkg::CFG_W : AW + 1;
	localparam int EW = ((itl_pkg::IDX_W > AW) ? itl_pkg::IDX_W : AW) + 1;

	logic [itl_pkg::CFG_W-1:0] entries_q;

	logic [itl_pkg::KEY_W-1:0] e_q;
	logic [AW-1:0]             lo_q;
	logic [AW-1:0]             hi_q;
	logic [itl_pkg::KEY_W-1:0] k0_q;
	logic [itl_pkg::KEY_W-1:0] k1_q;
	logic [itl_pkg::VAL_W-1:0] v0_q;
	logic [itl_pkg::VAL_W-1:0] v1_q;
	logic [itl_pkg::KEY_W-1:0] de_q;
	logic [itl_pkg::KEY_W-1:0] dk_q;
	logic [itl_pkg::VAL_W-1:0] mag_q;
	logic                      neg_q;
	logic [2*itl_pkg::HALF_W-1:0] prod_s1;
	itl_pkg::mul_sel_t         psel_s1;
	logic                      prod_vld_s1;
	logic [itl_pkg::PROD_W-1:0] acc_q;
	logic [itl_pkg::VAL_W-1:0] res_q;
	logic [itl_pkg::IDX_W-1:0] res_idx_q;

	logic                      out_valid_q;
	itl_pkg::status_t          out_status_q;
	logic [itl_pkg::VAL_W-1:0] out_value_q;
	logic [itl_pkg::IDX_W-1:0] out_index_q;

	logic [NW-1:0]             n_ext;
	logic [NW-1:0]             n_eff;
	logic [NW-1:0]             n_m1;
	logic [AW-1:0]             last_idx;
	logic [EW-1:0]             idx_ext;
	logic                      in_range;
	logic [AW:0]               sum;
	logic [AW-1:0]             mid;
	logic [AW-1:0]             span;
	logic [AW-1:0]             rd_addr;
	logic [itl_pkg::KEY_W-1:0] rd_key;
	logic [itl_pkg::VAL_W-1:0] rd_val;
	logic [itl_pkg::HALF_W-1:0] op_a;
	logic [itl_pkg::HALF_W-1:0] op_b;
	logic [2*itl_pkg::HALF_W-1:0] mul_prod;
	logic [itl_pkg::SH_W-1:0]  shamt;
	logic [itl_pkg::VAL_W-1:0] quotient;
	logic                      div_done;
	logic                      out_xfer;
	logic                      out_free;

	always_comb begin
		n_ext    = NW'(entries_q);
		n_eff    = (n_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : n_ext;
		n_m1     = n_eff - NW'(1);
		last_idx = n_m1[AW-1:0];
		idx_ext  = EW'(entry_index);
		in_range = idx_ext < EW'(TABLE_DEPTH);
		sum      = {1'b0, lo_q} + {1'b0, hi_q};
		mid      = sum[AW:1];
		span     = hi_q - lo_q;
	end

	always_comb begin
		unique case (cmd.addr_sel)
			itl_pkg::A_ZERO: rd_addr = '0;
			itl_pkg::A_MID:  rd_addr = mid;
			itl_pkg::A_LO:   rd_addr = lo_q;
			itl_pkg::A_HI:   rd_addr = hi_q;
			default:         rd_addr = '0;
		endcase
	end

	itl_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (cmd.wr_en && in_range),
		.wr_addr(idx_ext[AW-1:0]),
		.wr_key (key_word),
		.wr_val (value_word),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_key (rd_key),
		.rd_val (rd_val)
	);

	always_comb begin
		unique case (cmd.mul_sel)
			itl_pkg::MUL_LL: begin
				op_a = de_q[itl_pkg::HALF_W-1:0];
				op_b = mag_q[itl_pkg::HALF_W-1:0];
			end
			itl_pkg::MUL_LH: begin
				op_a = de_q[itl_pkg::HALF_W-1:0];
				op_b = itl_pkg::HALF_W'(mag_q[itl_pkg::VAL_W-1:itl_pkg::HALF_W]);
			end
			itl_pkg::MUL_HL: begin
				op_a = itl_pkg::HALF_W'(de_q[itl_pkg::KEY_W-1:itl_pkg::HALF_W]);
				op_b = mag_q[itl_pkg::HALF_W-1:0];
			end
			itl_pkg::MUL_HH: begin
				op_a = itl_pkg::HALF_W'(de_q[itl_pkg::KEY_W-1:itl_pkg::HALF_W]);
				op_b = itl_pkg::HALF_W'(mag_q[itl_pkg::VAL_W-1:itl_pkg::HALF_W]);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		mul_prod = op_a * op_b;
	end

	always_comb begin
		case (psel_s1) inside
			itl_pkg::MUL_LH, itl_pkg::MUL_HL: shamt = itl_pkg::SH_W'(itl_pkg::HALF_W);
			itl_pkg::MUL_HH:                  shamt = itl_pkg::SH_W'(2 * itl_pkg::HALF_W);
			default:                          shamt = '0;
		endcase
	end

	itl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dvd_hi  (acc_q[itl_pkg::PROD_W-1:itl_pkg::VAL_W]),
		.dvd_lo  (acc_q[itl_pkg::VAL_W-1:0]),
		.divisor (dk_q),
		.quotient(quotient),
		.done    (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q   <= '0;
			prod_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				entries_q <= cfg_write_data;
			end
			prod_vld_s1 <= cmd.mul_en;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			e_q  <= energy;
			lo_q <= '0;
			hi_q <= last_idx;
		end else if (cmd.step) begin
			if (e_q < rd_key) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid;
			end
		end
		if (cmd.cap_lo) begin
			k0_q <= rd_key;
			v0_q <= rd_val;
		end
		if (cmd.cap_hi) begin
			k1_q <= rd_key;
			v1_q <= rd_val;
		end
		if (cmd.prep) begin
			de_q  <= e_q - k0_q;
			dk_q  <= k1_q - k0_q;
			neg_q <= v1_q < v0_q;
			mag_q <= (v1_q < v0_q) ? (v0_q - v1_q) : (v1_q - v0_q);
		end
		if (cmd.mul_en) begin
			prod_s1 <= mul_prod;
			psel_s1 <= cmd.mul_sel;
		end
		if (cmd.prep) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + (itl_pkg::PROD_W'(prod_s1) << shamt);
		end
		if (cmd.res_en) begin
			res_q     <= neg_q ? (v0_q - quotient) : (v0_q + quotient);
			res_idx_q <= itl_pkg::IDX_W'(lo_q);
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			if (cmd.out_status == itl_pkg::ST_INTERP) begin
				out_value_q <= res_q;
				out_index_q <= res_idx_q;
			end else begin
				out_value_q <= '0;
				out_index_q <= '0;
			end
		end
	end

	assign out_xfer = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st.too_few     = n_eff < NW'(2);
		st.e_lt_key    = e_q < rd_key;
		st.search_done = span == AW'(1);
		st.out_free    = out_free;
		st.div_done    = div_done;
	end

	assign out_valid          = out_valid_q;
	assign status             = out_status_q;
	assign interpolated_value = out_value_q;
	assign found_index        = out_index_q;

	a_search_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (lo_q < hi_q))
		else $error("search interval collapsed");

endmodule
`default_nettype wire

### src/itl_ctrl.sv
`default_nettype none
module itl_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                command,
	input  wire itl_pkg::dp_status_t st,
	output itl_pkg::dp_cmd_t         cmd,
	output logic                     in_stall
);

	itl_pkg::state_t  state_q;
	itl_pkg::state_t  state_nxt;
	itl_pkg::status_t status_q;
	logic [itl_pkg::MUL_SEL_W-1:0] mul_cnt_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			itl_pkg::S_IDLE: begin
				if (in_valid) begin
					if (command == itl_pkg::CMD_QUERY) begin
						state_nxt = st.too_few ? itl_pkg::S_FINISH : itl_pkg::S_RD_FIRST;
					end else if (!st.out_free) begin
						state_nxt = itl_pkg::S_FINISH;
					end
				end
			end
			itl_pkg::S_RD_FIRST:   state_nxt = itl_pkg::S_CHK_FIRST;
			itl_pkg::S_CHK_FIRST: begin
				state_nxt = st.e_lt_key ? itl_pkg::S_FINISH : itl_pkg::S_CHK_LAST;
			end
			itl_pkg::S_CHK_LAST: begin
				state_nxt = st.e_lt_key ? itl_pkg::S_SRCH_ISSUE : itl_pkg::S_FINISH;
			end
			itl_pkg::S_SRCH_ISSUE: begin
				state_nxt = st.search_done ? itl_pkg::S_CAP_LO : itl_pkg::S_SRCH_CMP;
			end
			itl_pkg::S_SRCH_CMP:   state_nxt = itl_pkg::S_SRCH_ISSUE;
			itl_pkg::S_CAP_LO:     state_nxt = itl_pkg::S_CAP_HI;
			itl_pkg::S_CAP_HI:     state_nxt = itl_pkg::S_PREP;
			itl_pkg::S_PREP:       state_nxt = itl_pkg::S_MUL;
			itl_pkg::S_MUL: begin
				if (mul_cnt_q == itl_pkg::MUL_HH) begin
					state_nxt = itl_pkg::S_MUL_WAIT;
				end
			end
			itl_pkg::S_MUL_WAIT:   state_nxt = itl_pkg::S_DIV_START;
			itl_pkg::S_DIV_START:  state_nxt = itl_pkg::S_DIV_WAIT;
			itl_pkg::S_DIV_WAIT: begin
				if (st.div_done) begin
					state_nxt = itl_pkg::S_RESULT;
				end
			end
			itl_pkg::S_RESULT:     state_nxt = itl_pkg::S_FINISH;
			itl_pkg::S_FINISH: begin
				if (st.out_free) begin
					state_nxt = itl_pkg::S_IDLE;
				end
			end
			default:               state_nxt = itl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			itl_pkg::S_IDLE: begin
				if (in_valid) begin
					if (command == itl_pkg::CMD_QUERY) begin
						cmd.capture = 1'b1;
					end else begin
						cmd.wr_en = 1'b1;
						if (st.out_free) begin
							cmd.out_load   = 1'b1;
							cmd.out_status = itl_pkg::ST_WRITTEN;
						end
					end
				end
			end
			itl_pkg::S_RD_FIRST: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = itl_pkg::A_ZERO;
			end
			itl_pkg::S_CHK_FIRST: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = itl_pkg::A_HI;
			end
			itl_pkg::S_SRCH_ISSUE: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = st.search_done ? itl_pkg::A_LO : itl_pkg::A_MID;
			end
			itl_pkg::S_SRCH_CMP: cmd.step = 1'b1;
			itl_pkg::S_CAP_LO: begin
				cmd.cap_lo   = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = itl_pkg::A_HI;
			end
			itl_pkg::S_CAP_HI: cmd.cap_hi = 1'b1;
			itl_pkg::S_PREP:   cmd.prep   = 1'b1;
			itl_pkg::S_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = itl_pkg::mul_sel_t'(mul_cnt_q);
			end
			itl_pkg::S_DIV_START: cmd.div_start = 1'b1;
			itl_pkg::S_RESULT:    cmd.res_en    = 1'b1;
			itl_pkg::S_FINISH: begin
				if (st.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = status_q;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= itl_pkg::S_IDLE;
			status_q  <= itl_pkg::ST_WRITTEN;
			mul_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				itl_pkg::S_IDLE: begin
					if (in_valid) begin
						status_q <= (command == itl_pkg::CMD_QUERY) ?
							itl_pkg::ST_TOO_FEW : itl_pkg::ST_WRITTEN;
					end
				end
				itl_pkg::S_CHK_FIRST: begin
					if (st.e_lt_key) begin
						status_q <= itl_pkg::ST_BELOW;
					end
				end
				itl_pkg::S_CHK_LAST: begin
					if (!st.e_lt_key) begin
						status_q <= itl_pkg::ST_ABOVE;
					end
				end
				itl_pkg::S_PREP:   mul_cnt_q <= '0;
				itl_pkg::S_MUL:    mul_cnt_q <= mul_cnt_q + itl_pkg::MUL_SEL_W'(1);
				itl_pkg::S_RESULT: status_q  <= itl_pkg::ST_INTERP;
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != itl_pkg::S_IDLE);

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over a held result");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == itl_pkg::S_DIV_WAIT))
		else $error("division finished outside its wait state");

endmodule
`default_nettype wire

### src/interpolated_table_lookup.sv
// Piecewise linear lookup over a table of ascending keys and their values.
// Input channel (in_valid / in_stall): command 0 writes key_word and
// value_word at entry_index; command 1 queries at energy (Q39.24). Output
// channel (out_valid / out_stall) gives one result per transfer: status,
// interpolated_value (Q31.32) and found_index.
// cfg_write_en / cfg_write_data set entries_in_use; write it only while idle.
// A write stores the entry when taken and loads its result with it if the
// output slot is free. A query runs two table reads for the range checks,
// a binary search in which each halving is one registered memory read and
// one compare, two reads for the interval ends, a 63x63 multiply as four
// 32x32 partial products, and a bit-serial division of 63 steps. The search
// takes at most ceil(log2(n-1)) halvings for n entries in use. Queries with
// too few entries end at once, queries below or above the table after the
// range checks.
// One item is in work at a time; in_stall is high while it runs.
// A finished result waits in the output register while out_stall is high;
// a new item is still taken if the block is idle, and its result waits
// until the slot frees. Reset clears the control state, the output valid
// and entries_in_use; table contents are undefined until written.
`default_nettype none
module interpolated_table_lookup #(
	parameter int TABLE_DEPTH = itl_pkg::DEFAULT_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write_en,
	input  wire logic [itl_pkg::CFG_W-1:0]    cfg_write_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         command,
	input  wire logic [itl_pkg::IDX_W-1:0]    entry_index,
	input  wire logic [itl_pkg::KEY_W-1:0]    key_word,
	input  wire logic [itl_pkg::VAL_W-1:0]    value_word,
	input  wire logic [itl_pkg::KEY_W-1:0]    energy,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [itl_pkg::STATUS_W-1:0] status,
	output logic      [itl_pkg::VAL_W-1:0]    interpolated_value,
	output logic      [itl_pkg::IDX_W-1:0]    found_index
);

	itl_pkg::dp_cmd_t    cmd;
	itl_pkg::dp_status_t st;

	itl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.command (command),
		.st      (st),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	itl_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_write_data    (cfg_write_data),
		.entry_index       (entry_index),
		.key_word          (key_word),
		.value_word        (value_word),
		.energy            (energy),
		.out_stall         (out_stall),
		.cmd               (cmd),
		.st                (st),
		.out_valid         (out_valid),
		.status            (status),
		.interpolated_value(interpolated_value),
		.found_index       (found_index)
	);

endmodule
`default_nettype wire
